### rtl/core/i2c_rm_pkg.sv
// Package for the register-addressed I2C master: bus phases, byte roles,
// item payload types and register indexes. No dependencies.
package i2c_rm_pkg;

  localparam int unsigned DevAddrW = 7;
  localparam int unsigned TickW    = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [DevAddrW-1:0] DevAddrReset    = 7'd81;
  localparam logic [TickW-1:0]    HalfPeriodReset = 16'd250;
  localparam logic [TickW-1:0]    AckTimeoutReset = 16'd2550;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_S0    = 5'd1,
    PH_S1    = 5'd2,
    PH_S2    = 5'd3,
    PH_S3    = 5'd4,
    PH_WLO   = 5'd5,
    PH_WHI   = 5'd6,
    PH_ALO   = 5'd7,
    PH_AHI   = 5'd8,
    PH_AWAIT = 5'd9,
    PH_AEND  = 5'd10,
    PH_RLO   = 5'd11,
    PH_RHI   = 5'd12,
    PH_MLO   = 5'd13,
    PH_MHI   = 5'd14,
    PH_P0    = 5'd15,
    PH_P1    = 5'd16,
    PH_P2    = 5'd17
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_ADDR_W = 2'd0,
    ROLE_REG    = 2'd1,
    ROLE_DATA   = 2'd2,
    ROLE_ADDR_R = 2'd3
  } role_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        reg_addr;
    logic [CountW-1:0] byte_count;
    logic [7:0]        wr_data;
    logic              sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       byte_taken;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       busy_res;
    logic       ack_error;
    logic       done_res;
  } res_t;

endpackage

### rtl/core/i2c_rm_if.sv
// Valid/ready channels for the I2C master: command items in, result items out.
// Depends on i2c_rm_pkg for the payload types.
interface i2c_rm_cmd_if;
  logic               valid;
  logic               ready;
  i2c_rm_pkg::cmd_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2c_rm_res_if;
  logic               valid;
  logic               ready;
  i2c_rm_pkg::res_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/i2c_register_master.sv
// Channel  Dir  Payload                                   Accepted when
// cmd_i    in   op, reg_addr, byte_count, wr_data, sda_in valid & ready
// res_o    out  scl, sda_out, byte_taken, rd_data, ...    valid & ready
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i           cfg_we_i
//
// One item is one bus tick: one item a cycle while the result channel is not stalled.
// The sequencer state and the result register update on the same edge.
// Reset returns the bus to idle with the register reset values.
// A stalled result holds; a new item is taken in the cycle it leaves.
// Depends on i2c_rm_pkg and i2c_rm_if.
module i2c_register_master #(
  parameter int unsigned MaxBurst = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [i2c_rm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [i2c_rm_pkg::TickW-1:0]       cfg_data_i,
  i2c_rm_cmd_if.sink                         cmd_i,
  i2c_rm_res_if.source                       res_o
);
  import i2c_rm_pkg::*;

  logic [DevAddrW-1:0] dev_addr_q;
  logic [TickW-1:0]    half_period_q, ack_timeout_q;

  phase_e              phase_q, phase_d;
  role_e               role_q, role_d;
  logic [2:0]          bit_idx_q, bit_idx_d;
  logic [7:0]          shift_q, shift_d;
  logic [TickW-1:0]    delay_q, delay_d;
  logic [TickW-1:0]    wait_q, wait_d;
  logic [CountW-1:0]   bytes_left_q, bytes_left_d;
  logic [7:0]          held_reg_q, held_reg_d;
  logic                is_read_q, is_read_d;
  logic                err_q, err_d;

  res_t                res_q, res_d;
  logic                res_valid_q;
  logic                accept;

  logic [TickW-1:0]    hp;
  logic [TickW:0]      delay_inc, wait_inc;
  logic                ends;
  logic [CountW-1:0]   n_req;
  logic [CountW-1:0]   bytes_dec;
  logic [7:0]          rx_shift;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  assign hp        = (half_period_q == '0) ? TickW'(1) : half_period_q;
  assign delay_inc = {1'b0, delay_q} + 1'b1;
  assign wait_inc  = {1'b0, wait_q} + 1'b1;
  assign ends      = delay_inc >= {1'b0, hp};
  assign bytes_dec = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : bytes_left_q;
  assign rx_shift  = {shift_q[6:0], cmd_i.data.sda_in};

  always_comb begin
    n_req = cmd_i.data.byte_count;
    if (n_req == '0) begin
      n_req = CountW'(1);
    end
    if (9'(n_req) > 9'(MaxBurst)) begin
      n_req = CountW'(MaxBurst);
    end
  end

  always_comb begin
    phase_d      = phase_q;
    role_d       = role_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    delay_d      = delay_q;
    wait_d       = wait_q;
    bytes_left_d = bytes_left_q;
    held_reg_d   = held_reg_q;
    is_read_d    = is_read_q;
    err_d        = err_q;
    res_d        = '0;
    res_d.scl     = 1'b1;
    res_d.sda_out = 1'b1;
    res_d.busy_res = (phase_q != PH_IDLE);

    case (phase_q)
      PH_S0:   begin res_d.scl = 1'b0; end
      PH_S2:   begin res_d.sda_out = 1'b0; end
      PH_S3:   begin res_d.scl = 1'b0; res_d.sda_out = 1'b0; end
      PH_WLO:  begin res_d.scl = 1'b0; res_d.sda_out = shift_q[7]; end
      PH_WHI:  begin res_d.sda_out = shift_q[7]; end
      PH_ALO, PH_AEND, PH_RLO: begin res_d.scl = 1'b0; end
      PH_MLO:  begin res_d.scl = 1'b0; res_d.sda_out = (bytes_left_q <= CountW'(1)); end
      PH_MHI:  begin res_d.sda_out = (bytes_left_q <= CountW'(1)); end
      PH_P0:   begin res_d.scl = 1'b0; res_d.sda_out = 1'b0; end
      PH_P1:   begin res_d.sda_out = 1'b0; end
      default: begin end
    endcase

    if (phase_q == PH_IDLE) begin
      if (cmd_i.data.op == OP_WRITE || cmd_i.data.op == OP_READ) begin
        bytes_left_d = n_req;
        held_reg_d   = cmd_i.data.reg_addr;
        is_read_d    = (cmd_i.data.op == OP_READ);
        err_d        = 1'b0;
        wait_d       = '0;
        shift_d      = {dev_addr_q, 1'b0};
        role_d       = ROLE_ADDR_W;
        bit_idx_d    = '0;
        phase_d      = PH_S0;
        delay_d      = '0;
      end
    end else if (phase_q == PH_AWAIT) begin
      if (!cmd_i.data.sda_in) begin
        phase_d = PH_AEND;
        delay_d = '0;
      end else if (wait_inc >= {1'b0, ack_timeout_q}) begin
        err_d   = 1'b1;
        phase_d = PH_P0;
        delay_d = '0;
      end else begin
        wait_d = wait_inc[TickW-1:0];
      end
    end else if (!ends) begin
      delay_d = delay_inc[TickW-1:0];
    end else begin
      delay_d = '0;
      case (phase_q)
        PH_S0: phase_d = PH_S1;
        PH_S1: phase_d = PH_S2;
        PH_S2: phase_d = PH_S3;
        PH_S3: begin bit_idx_d = '0; phase_d = PH_WLO; end
        PH_WLO: phase_d = PH_WHI;
        PH_WHI: begin
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_idx_q == 3'd7) begin
            bit_idx_d = '0;
            phase_d   = PH_ALO;
          end else begin
            bit_idx_d = bit_idx_q + 1'b1;
            phase_d   = PH_WLO;
          end
        end
        PH_ALO: phase_d = PH_AHI;
        PH_AHI: begin wait_d = '0; phase_d = PH_AWAIT; end
        PH_AEND: begin
          case (role_q)
            ROLE_ADDR_W: begin
              shift_d   = held_reg_q;
              role_d    = ROLE_REG;
              bit_idx_d = '0;
              phase_d   = PH_WLO;
            end
            ROLE_REG: begin
              if (is_read_q) begin
                shift_d = {dev_addr_q, 1'b1};
                role_d  = ROLE_ADDR_R;
                phase_d = PH_S0;
              end else begin
                shift_d   = cmd_i.data.wr_data;
                role_d    = ROLE_DATA;
                bit_idx_d = '0;
                phase_d   = PH_WLO;
                res_d.byte_taken = 1'b1;
              end
            end
            ROLE_DATA: begin
              bytes_left_d = bytes_dec;
              if (bytes_dec == '0) begin
                phase_d = PH_P0;
              end else begin
                shift_d   = cmd_i.data.wr_data;
                bit_idx_d = '0;
                phase_d   = PH_WLO;
                res_d.byte_taken = 1'b1;
              end
            end
            default: begin
              bit_idx_d = '0;
              shift_d   = '0;
              phase_d   = PH_RLO;
            end
          endcase
        end
        PH_RLO: phase_d = PH_RHI;
        PH_RHI: begin
          shift_d = rx_shift;
          if (bit_idx_q == 3'd7) begin
            bit_idx_d      = '0;
            res_d.rd_data  = rx_shift;
            res_d.rd_valid = 1'b1;
            res_d.rd_last  = (bytes_left_q <= CountW'(1));
            phase_d        = PH_MLO;
          end else begin
            bit_idx_d = bit_idx_q + 1'b1;
            phase_d   = PH_RLO;
          end
        end
        PH_MLO: phase_d = PH_MHI;
        PH_MHI: begin
          bytes_left_d = bytes_dec;
          if (bytes_dec == '0) begin
            phase_d = PH_P0;
          end else begin
            shift_d = '0;
            phase_d = PH_RLO;
          end
        end
        PH_P0: phase_d = PH_P1;
        PH_P1: phase_d = PH_P2;
        PH_P2: begin res_d.done_res = 1'b1; phase_d = PH_IDLE; end
        default: phase_d = PH_IDLE;
      endcase
    end

    res_d.ack_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      half_period_q <= HalfPeriodReset;
      ack_timeout_q <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEV_ADDR:    dev_addr_q    <= cfg_data_i[DevAddrW-1:0];
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i;
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      role_q       <= ROLE_ADDR_W;
      bit_idx_q    <= '0;
      shift_q      <= '0;
      delay_q      <= '0;
      wait_q       <= '0;
      bytes_left_q <= '0;
      held_reg_q   <= '0;
      is_read_q    <= 1'b0;
      err_q        <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        role_q       <= role_d;
        bit_idx_q    <= bit_idx_d;
        shift_q      <= shift_d;
        delay_q      <= delay_d;
        wait_q       <= wait_d;
        bytes_left_q <= bytes_left_d;
        held_reg_q   <= held_reg_d;
        is_read_q    <= is_read_d;
        err_q        <= err_d;
        res_valid_q  <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.rd_last |-> res_q.rd_valid)
    else $error("rd_last without rd_valid");

  a_taken_not_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.byte_taken |-> !res_q.rd_valid && res_q.busy_res)
    else $error("byte taken outside a write transfer");

  a_idle_delay_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> delay_q == '0)
    else $error("delay counter running while idle");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_P2 && ends |=> phase_q == PH_IDLE && res_q.done_res)
    else $error("stop did not return to idle");

endmodule

### tb/i2c_register_master_tb.sv
// Self-checking bench for i2c_register_master: drives bus ticks over the command
// channel, predicts each result item (or takes it from a fixed plan row) and compares it field by field.
// Depends on i2c_rm_pkg, i2c_rm_if and the i2c_register_master RTL.
module i2c_register_master_tb;
  import i2c_rm_pkg::*;

  localparam int unsigned BURST_MAX   = 16;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  localparam res_t BUS_IDLE  = '{scl: 1'b1, sda_out: 1'b1, default: '0};
  localparam res_t ERR_IDLE  = '{scl: 1'b1, sda_out: 1'b1, ack_error: 1'b1, default: '0};
  localparam res_t START_LO  = '{scl: 1'b0, sda_out: 1'b1, busy_res: 1'b1, default: '0};
  localparam res_t START_HI  = '{scl: 1'b1, sda_out: 1'b1, busy_res: 1'b1, default: '0};
  localparam res_t START_SDA = '{scl: 1'b1, sda_out: 1'b0, busy_res: 1'b1, default: '0};
  localparam res_t START_END = '{scl: 1'b0, sda_out: 1'b0, busy_res: 1'b1, default: '0};

  typedef enum logic [1:0] {
    ROW_TICK   = 2'd0,
    ROW_CFG    = 2'd1,
    ROW_ACKED  = 2'd2,
    ROW_NACKED = 2'd3
  } row_e;

  typedef struct packed {
    row_e               kind;
    logic [CfgIdxW-1:0] idx;
    logic [TickW-1:0]   val;
    cmd_t               tick;
    logic               fixed;
    res_t               want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [TickW-1:0]    cfg_data_i;

  i2c_rm_cmd_if cmd_ch ();
  i2c_rm_res_if res_ch ();

  i2c_register_master #(
    .MaxBurst (BURST_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_ch.sink),
    .res_o      (res_ch.source)
  );

  // bus sequencer mirror
  logic [DevAddrW-1:0] dev_addr   = DevAddrReset;
  logic [TickW-1:0]    half_per   = HalfPeriodReset;
  logic [TickW-1:0]    ack_limit  = AckTimeoutReset;
  phase_e              ph         = PH_IDLE;
  role_e               byte_role  = ROLE_ADDR_W;
  logic [3:0]          bit_idx    = '0;
  logic [7:0]          shreg      = '0;
  logic [TickW-1:0]    dly        = '0;
  logic [TickW-1:0]    waitc      = '0;
  logic [CountW-1:0]   left       = '0;
  logic [7:0]          reg_hold   = '0;
  logic                rd_mode    = 1'b0;
  logic                err        = 1'b0;

  res_t        due_outputs [$];
  res_t        head;
  int unsigned bad_fields  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned calm_left   = 0;
  int unsigned steady_left = 0;
  logic        noisy       = 1'b0;
  row_t        plan [$];

  function automatic void move_to(phase_e p);
    ph  = p;
    dly = '0;
  endfunction

  function automatic void load_byte(logic [7:0] v, role_e ro);
    shreg     = v;
    byte_role = ro;
    bit_idx   = '0;
    move_to(PH_WLO);
  endfunction

  function automatic res_t bus_tick(cmd_t c);
    res_t             r;
    logic [TickW-1:0] hp;
    logic [CountW-1:0] n;
    r          = '0;
    r.scl      = 1'b1;
    r.sda_out  = 1'b1;
    r.busy_res = (ph != PH_IDLE);
    hp         = (half_per == '0) ? 16'd1 : half_per;
    case (ph)
      PH_S0, PH_ALO, PH_AEND, PH_RLO: {r.scl, r.sda_out} = 2'b01;
      PH_S2, PH_P1:                   {r.scl, r.sda_out} = 2'b10;
      PH_S3, PH_P0:                   {r.scl, r.sda_out} = 2'b00;
      PH_WLO:                         {r.scl, r.sda_out} = {1'b0, shreg[7]};
      PH_WHI:                         {r.scl, r.sda_out} = {1'b1, shreg[7]};
      PH_MLO:                         {r.scl, r.sda_out} = {1'b0, left <= 1};
      PH_MHI:                         {r.scl, r.sda_out} = {1'b1, left <= 1};
      default:                        {r.scl, r.sda_out} = 2'b11;
    endcase

    if (ph == PH_IDLE) begin
      if (c.op == OP_WRITE || c.op == OP_READ) begin
        n = c.byte_count;
        if (n == '0) n = CountW'(1);
        if (n > BURST_MAX) n = CountW'(BURST_MAX);
        left      = n;
        reg_hold  = c.reg_addr;
        rd_mode   = (c.op == OP_READ);
        err       = 1'b0;
        waitc     = '0;
        shreg     = {dev_addr, 1'b0};
        byte_role = ROLE_ADDR_W;
        bit_idx   = '0;
        move_to(PH_S0);
      end
    end else if (ph == PH_AWAIT) begin
      if (!c.sda_in) begin
        move_to(PH_AEND);
      end else if (waitc + 1 >= ack_limit) begin
        err = 1'b1;
        move_to(PH_P0);
      end else begin
        waitc++;
      end
    end else if (dly + 1 < hp) begin
      dly++;
    end else begin
      dly = '0;
      case (ph)
        PH_S0: move_to(PH_S1);
        PH_S1: move_to(PH_S2);
        PH_S2: move_to(PH_S3);
        PH_S3: begin
          bit_idx = '0;
          move_to(PH_WLO);
        end
        PH_WLO: move_to(PH_WHI);
        PH_WHI: begin
          shreg = shreg << 1;
          if (bit_idx >= 7) begin
            bit_idx = '0;
            move_to(PH_ALO);
          end else begin
            bit_idx++;
            move_to(PH_WLO);
          end
        end
        PH_ALO: move_to(PH_AHI);
        PH_AHI: begin
          waitc = '0;
          move_to(PH_AWAIT);
        end
        PH_AEND: begin
          case (byte_role)
            ROLE_ADDR_W: load_byte(reg_hold, ROLE_REG);
            ROLE_REG: begin
              if (rd_mode) begin
                shreg     = {dev_addr, 1'b1};
                byte_role = ROLE_ADDR_R;
                move_to(PH_S0);
              end else begin
                load_byte(c.wr_data, ROLE_DATA);
                r.byte_taken = 1'b1;
              end
            end
            ROLE_DATA: begin
              if (left > 0) left--;
              if (left == 0) begin
                move_to(PH_P0);
              end else begin
                load_byte(c.wr_data, ROLE_DATA);
                r.byte_taken = 1'b1;
              end
            end
            default: begin
              bit_idx = '0;
              shreg   = '0;
              move_to(PH_RLO);
            end
          endcase
        end
        PH_RLO: move_to(PH_RHI);
        PH_RHI: begin
          shreg = {shreg[6:0], c.sda_in};
          if (bit_idx >= 7) begin
            bit_idx    = '0;
            r.rd_data  = shreg;
            r.rd_valid = 1'b1;
            r.rd_last  = (left <= 1);
            move_to(PH_MLO);
          end else begin
            bit_idx++;
            move_to(PH_RLO);
          end
        end
        PH_MLO: move_to(PH_MHI);
        PH_MHI: begin
          if (left > 0) left--;
          if (left == 0) begin
            move_to(PH_P0);
          end else begin
            shreg = '0;
            move_to(PH_RLO);
          end
        end
        PH_P0: move_to(PH_P1);
        PH_P1: move_to(PH_P2);
        PH_P2: begin
          r.done_res = 1'b1;
          move_to(PH_IDLE);
        end
        default: move_to(PH_IDLE);
      endcase
    end
    r.ack_error = err;
    return r;
  endfunction

  function automatic row_t tick_row(op_e op, logic [7:0] ra, logic [CountW-1:0] cnt,
                                    logic [7:0] wd, logic sda, logic fixed, res_t want);
    row_t row;
    row       = '0;
    row.kind  = ROW_TICK;
    row.tick  = '{op: op, reg_addr: ra, byte_count: cnt, wr_data: wd, sda_in: sda};
    row.fixed = fixed;
    row.want  = want;
    return row;
  endfunction

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] val);
    row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  function automatic row_t run_row(row_e kind);
    row_t row;
    row      = '0;
    row.kind = kind;
    return row;
  endfunction

  function automatic cmd_t next_tick();
    cmd_t c;
    c.reg_addr   = 8'($urandom);
    c.wr_data    = 8'($urandom);
    c.byte_count = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 3));
    if (ph == PH_IDLE) begin
      if ($urandom_range(0, 7) != 0) begin
        c.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      end else begin
        c.op = $urandom_range(0, 1) ? OP_NONE : OP_RSVD;
      end
      noisy = ($urandom_range(0, 4) == 0);
    end else begin
      c.op = 2'($urandom_range(0, 3));
    end
    if (ph == PH_AWAIT && !noisy) begin
      c.sda_in = ($urandom_range(0, 3) == 0);
    end else begin
      c.sda_in = 1'($urandom_range(0, 1));
    end
    return c;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad_fields++;
    end
  endfunction

  task automatic send_tick(input cmd_t c, input logic fixed, input res_t want);
    res_t        r;
    int unsigned gap;
    int unsigned pick;
    logic        pause;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    cfg_we_i     <= 1'b0;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    r = bus_tick(c);
    due_outputs.push_back(fixed ? want : r);
    gap   = 0;
    pause = 1'b0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      pick = $urandom_range(0, 299);
      if (pick < 210) gap = 0;
      else if (pick < 279) gap = $urandom_range(1, 3);
      else if (pick < 294) gap = $urandom_range(8, 15);
      else if (pick < 298) steady_left = $urandom_range(100, 300);
      else pause = 1'b1;
    end
    if (pause && due_outputs.size() != 0) begin
      cmd_ch.valid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clk_i);
    end else if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_to_idle(input logic refuse);
    cmd_t c;
    while (ph != PH_IDLE) begin
      c.op         = 2'($urandom_range(0, 3));
      c.reg_addr   = 8'($urandom);
      c.byte_count = 5'($urandom);
      c.wr_data    = 8'($urandom);
      c.sda_in     = refuse ? 1'b1 : ((ph == PH_AWAIT) ? 1'b0 : 1'($urandom_range(0, 1)));
      send_tick(c, 1'b0, '0);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
    run_to_idle(1'b0);
    cmd_ch.valid <= 1'b0;
    if (due_outputs.size() != 0) begin
      cfg_we_i <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clk_i);
    end
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DEV_ADDR:    dev_addr  = val[DevAddrW-1:0];
      CFG_HALF_PERIOD: half_per  = val;
      CFG_ACK_TIMEOUT: ack_limit = val;
      default: ;
    endcase
  endtask

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (due_outputs.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        bad_fields++;
      end else begin
        head = due_outputs.pop_front();
        check_field("scl", 8'(head.scl), 8'(res_ch.data.scl));
        check_field("sda_out", 8'(head.sda_out), 8'(res_ch.data.sda_out));
        check_field("byte_taken", 8'(head.byte_taken), 8'(res_ch.data.byte_taken));
        check_field("rd_data", head.rd_data, res_ch.data.rd_data);
        check_field("rd_valid", 8'(head.rd_valid), 8'(res_ch.data.rd_valid));
        check_field("rd_last", 8'(head.rd_last), 8'(res_ch.data.rd_last));
        check_field("busy_res", 8'(head.busy_res), 8'(res_ch.data.busy_res));
        check_field("ack_error", 8'(head.ack_error), 8'(res_ch.data.ack_error));
        check_field("done_res", 8'(head.done_res), 8'(res_ch.data.done_res));
      end
    end
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  ;
          [70:94]: stall_left = $urandom_range(1, 3);
          [95:97]: stall_left = $urandom_range(8, 12);
          default: calm_left = $urandom_range(50, 200);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("i2c_register_master test failed");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    res_ch.ready = 1'b0;

    plan = '{
      tick_row(OP_NONE,  8'h00, 5'd0,  8'h00, 1'b1, 1'b1, BUS_IDLE),
      tick_row(OP_RSVD,  8'hFF, 5'd31, 8'hFF, 1'b0, 1'b1, BUS_IDLE),
      cfg_row(CFG_HALF_PERIOD, 16'd1),
      tick_row(OP_WRITE, 8'hA5, 5'd1,  8'h3C, 1'b1, 1'b1, BUS_IDLE),
      tick_row(OP_READ,  8'h00, 5'd5,  8'h00, 1'b0, 1'b1, START_LO),
      run_row(ROW_ACKED),
      cfg_row(CFG_ACK_TIMEOUT, 16'd2),
      cfg_row(CFG_DEV_ADDR, 16'hFF7F),
      tick_row(OP_READ,  8'hFF, 5'd31, 8'hFF, 1'b1, 1'b1, BUS_IDLE),
      tick_row(OP_NONE,  8'h00, 5'd0,  8'h00, 1'b0, 1'b1, START_LO),
      tick_row(OP_WRITE, 8'h00, 5'd0,  8'h00, 1'b1, 1'b1, START_HI),
      tick_row(OP_NONE,  8'h00, 5'd0,  8'h00, 1'b0, 1'b1, START_SDA),
      tick_row(OP_NONE,  8'h00, 5'd0,  8'h00, 1'b1, 1'b1, START_END),
      run_row(ROW_ACKED),
      cfg_row(CFG_DEV_ADDR, 16'h0080),
      cfg_row(CFG_ACK_TIMEOUT, 16'd0),
      tick_row(OP_WRITE, 8'h00, 5'd16, 8'h00, 1'b1, 1'b1, BUS_IDLE),
      run_row(ROW_NACKED),
      tick_row(OP_NONE,  8'h00, 5'd0,  8'h00, 1'b1, 1'b1, ERR_IDLE),
      cfg_row(CFG_HALF_PERIOD, 16'd0),
      cfg_row(CFG_ACK_TIMEOUT, 16'hFFFF),
      tick_row(OP_WRITE, 8'h5A, 5'd2,  8'hC3, 1'b0, 1'b1, BUS_IDLE),
      run_row(ROW_ACKED),
      cfg_row(CFG_HALF_PERIOD, 16'hFFFF),
      tick_row(OP_RSVD,  8'h81, 5'd17, 8'h7E, 1'b1, 1'b1, BUS_IDLE),
      cfg_row(CFG_SPARE, 16'hFFFF)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_TICK:   send_tick(plan[i].tick, plan[i].fixed, plan[i].want);
        ROW_CFG:    write_reg(plan[i].idx, plan[i].val);
        ROW_ACKED:  run_to_idle(1'b0);
        ROW_NACKED: run_to_idle(1'b1);
        default: ;
      endcase
    end

    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_DEV_ADDR, 16'($urandom_range(0, 65535)));
      write_reg(CFG_HALF_PERIOD, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 4))
                                                            : 16'($urandom_range(0, 1)));
      write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(0, 12)));
      for (int k = 0; k < 50; k++) send_tick(next_tick(), 1'b0, '0);
    end
    run_to_idle(1'b0);
    cmd_ch.valid <= 1'b0;
    cfg_we_i     <= 1'b0;

    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (bad_fields == 0) begin
      $display("i2c_register_master test passed");
    end else begin
      $display("i2c_register_master test failed");
    end
    $finish;
  end

endmodule
